// ===== hw/rtl/cbpa_pkg.sv =====
// Shared types and constants of the chained block pool allocator.
package cbpa_pkg;

  // Field widths.
  localparam int POOL_W = 9;
  localparam int BLK_W  = 16;

  // Empty chain marker.
  localparam logic [BLK_W-1:0] NIL_LINK = 16'hFFFF;

  // Operation codes.
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_INSPECT = 2'd2;

  // Status codes.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // One entry of the block table.
  typedef struct packed {
    logic [BLK_W-1:0] link;
    logic [BLK_W-1:0] epoch;
    logic             used;
  } entry_t;

  // Request word.
  typedef struct packed {
    logic [1:0]        func;
    logic [POOL_W-1:0] count;
    logic [BLK_W-1:0]  block;
  } req_t;

  // Response word.
  typedef struct packed {
    logic              status;
    logic [BLK_W-1:0]  head_block;
    logic [BLK_W-1:0]  next_link;
    logic [BLK_W-1:0]  block_epoch;
    logic              block_used;
    logic [POOL_W-1:0] free_total;
  } rsp_t;

endpackage

// ===== hw/rtl/cbpa_mem.sv =====
// Block table memory: one write port and one registered read port.
module cbpa_mem
  import cbpa_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/chained_block_pool_allocator.sv =====
// Top level of the chained block pool allocator: sequencer, state registers and output word.
//
// Usage: request words enter on req/req_valid/req_stall and response words leave on
// rsp/rsp_valid/rsp_stall. A word moves at a clock edge where valid is high and stall is low.
// Each request gives exactly one response word. The pool size is written through
// pool_we/pool_wdata while the block is idle; a write rebuilds the free stack.
// One request is handled at a time. The block table is a single memory with a registered
// read, so every visited block takes a read step and then a use step. Allocate of N blocks
// visits each block once, free of an N-block chain visits each twice (a checking walk, then
// an updating walk), a free refused at its k-th block stops there, inspect of a block in
// the pool reads it once, and a request that needs no table read goes straight to its
// response. req_stall is high while a request is in progress.
// Reset and pool writes: the table is cleared by a pass that writes one entry per cycle
// over every block of the pool, during which req_stall stays high.
// Receiver stall: the response is held in an output register; one further request is worked
// on meanwhile, and its finished response waits until the output register is free.
module chained_block_pool_allocator
  import cbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              pool_we,
  input  logic [POOL_W-1:0] pool_wdata
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [16:0] MAX_V = 17'(MAX_BLOCKS);
  localparam logic [POOL_W-1:0] POOL_RST =
    (MAX_BLOCKS < 256) ? POOL_W'(MAX_BLOCKS) : POOL_W'(256);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SWEEP  = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_DAT  = 4'd3;
  localparam logic [3:0] S_F1_RD  = 4'd4;
  localparam logic [3:0] S_F1_DAT = 4'd5;
  localparam logic [3:0] S_F2_RD  = 4'd6;
  localparam logic [3:0] S_F2_DAT = 4'd7;
  localparam logic [3:0] S_I_RD   = 4'd8;
  localparam logic [3:0] S_I_DAT  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0]        state;
  logic [POOL_W-1:0] pool;
  logic [POOL_W-1:0] tally;
  logic [BLK_W-1:0]  top;
  logic [BLK_W-1:0]  cur;
  logic [BLK_W-1:0]  head;
  logic [POOL_W-1:0] steps;
  logic [POOL_W-1:0] count;
  rsp_t              res;

  logic              mem_we;
  entry_t            mem_wdata;
  entry_t            rd;
  logic [BLK_W-1:0]  cur_inc;
  logic [POOL_W-1:0] pool_clamped;

  // True when an index lies inside the current pool.
  function automatic logic in_pool(input logic [BLK_W-1:0] x, input logic [POOL_W-1:0] p);
    return x < {{(BLK_W-POOL_W){1'b0}}, p};
  endfunction

  cbpa_mem #(
    .DEPTH(MAX_BLOCKS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(cur[AW-1:0]),
    .wdata(mem_wdata),
    .raddr(cur[AW-1:0]),
    .rdata(rd)
  );

  assign cur_inc   = cur + 16'd1;
  assign req_stall = (state != S_IDLE);

  // Saturate a written pool size to the supported range.
  always_comb begin
    if (pool_wdata == '0) begin
      pool_clamped = POOL_W'(1);
    end else if ({8'd0, pool_wdata} > MAX_V) begin
      pool_clamped = POOL_W'(MAX_BLOCKS);
    end else begin
      pool_clamped = pool_wdata;
    end
  end

  // Table write for the current step.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd;
    case (state)
      S_SWEEP: begin
        mem_we          = 1'b1;
        mem_wdata.link  = in_pool(cur_inc, pool) ? cur_inc : NIL_LINK;
        mem_wdata.epoch = '0;
        mem_wdata.used  = 1'b0;
      end
      S_A_DAT: begin
        mem_we         = 1'b1;
        mem_wdata.used = 1'b1;
        if (steps == count || !in_pool(rd.link, pool)) begin
          mem_wdata.link = NIL_LINK;
        end
      end
      S_F2_DAT: begin
        mem_we          = 1'b1;
        mem_wdata.used  = 1'b0;
        mem_wdata.epoch = rd.epoch + 16'd1;
        if (rd.link == NIL_LINK) begin
          mem_wdata.link = top;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      pool      <= POOL_RST;
      tally     <= POOL_RST;
      top       <= '0;
      cur       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // The output register empties when the receiver takes its word and no new one enters.
      if (rsp_valid && !rsp_stall && (pool_we || state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end

      if (pool_we) begin
        state <= S_SWEEP;
        pool  <= pool_clamped;
        tally <= pool_clamped;
        top   <= '0;
        cur   <= '0;
      end else begin
        case (state)
          S_SWEEP: begin
            cur <= cur_inc;
            if (cur_inc == {{(BLK_W-POOL_W){1'b0}}, pool}) begin
              state <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (req_valid) begin
              res.head_block  <= NIL_LINK;
              res.next_link   <= NIL_LINK;
              res.block_epoch <= '0;
              res.block_used  <= 1'b0;
              res.free_total  <= tally;
              count           <= req.count;
              case (req.func)
                FUNC_ALLOC: begin
                  steps <= POOL_W'(1);
                  head  <= top;
                  if (req.count == '0 || tally < req.count || !in_pool(top, pool)) begin
                    res.status <= STAT_FAIL;
                    state      <= S_FIN;
                  end else begin
                    res.status <= STAT_OK;
                    cur        <= top;
                    state      <= S_A_RD;
                  end
                end
                FUNC_FREE: begin
                  steps <= '0;
                  head  <= req.block;
                  if (req.block == NIL_LINK) begin
                    res.status <= STAT_FAIL;
                    state      <= S_FIN;
                  end else begin
                    res.status <= STAT_OK;
                    cur        <= req.block;
                    state      <= S_F1_RD;
                  end
                end
                FUNC_INSPECT: begin
                  res.status <= STAT_OK;
                  if (in_pool(req.block, pool)) begin
                    cur   <= req.block;
                    state <= S_I_RD;
                  end else begin
                    state <= S_FIN;
                  end
                end
                default: begin
                  res.status <= STAT_FAIL;
                  state      <= S_FIN;
                end
              endcase
            end
          end

          S_A_RD: begin
            state <= S_A_DAT;
          end

          // Mark one block used; the last block of the chain gets the empty link.
          S_A_DAT: begin
            if (steps == count || !in_pool(rd.link, pool)) begin
              top            <= rd.link;
              tally          <= tally - count;
              res.free_total <= tally - count;
              res.head_block <= head;
              state          <= S_FIN;
            end else begin
              cur   <= rd.link;
              steps <= steps + POOL_W'(1);
              state <= S_A_RD;
            end
          end

          S_F1_RD: begin
            state <= S_F1_DAT;
          end

          // Checking walk: every block must be in range and used, and the chain finite.
          S_F1_DAT: begin
            if (!in_pool(cur, pool) || !rd.used || steps == pool) begin
              res.status <= STAT_FAIL;
              state      <= S_FIN;
            end else begin
              steps <= steps + POOL_W'(1);
              if (rd.link == NIL_LINK) begin
                cur   <= head;
                state <= S_F2_RD;
              end else begin
                cur   <= rd.link;
                state <= S_F1_RD;
              end
            end
          end

          S_F2_RD: begin
            state <= S_F2_DAT;
          end

          // Updating walk: release each block; the tail links onto the old stack top.
          S_F2_DAT: begin
            if (rd.link == NIL_LINK) begin
              top            <= head;
              tally          <= tally + steps;
              res.free_total <= tally + steps;
              state          <= S_FIN;
            end else begin
              cur   <= rd.link;
              state <= S_F2_RD;
            end
          end

          S_I_RD: begin
            state <= S_I_DAT;
          end

          S_I_DAT: begin
            res.next_link   <= rd.link;
            res.block_epoch <= rd.epoch;
            res.block_used  <= rd.used;
            state           <= S_FIN;
          end

          // Hand the response to the output register once it is free.
          S_FIN: begin
            if (!rsp_valid || !rsp_stall) begin
              rsp_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!rsp_valid || !rsp_stall) && !pool_we) begin
      rsp <= res;
    end
  end

endmodule
